@@ hdl/wsp_pkg.sv @@
`default_nettype none
package wsp_pkg;

    localparam int WORD_W    = 32;
    localparam int NUM_REGS  = 8;
    localparam int ADDR_W    = 6;
    localparam int RECIP_SH  = 62;
    localparam int DIVQ_W    = 63;
    localparam int RATIO_W   = 49;
    localparam int HALF_W    = 12;

    // register indexes
    typedef enum logic [2:0] {
        REG_ROW0_LO = 3'd0,
        REG_ROW0_HI = 3'd1,
        REG_ROW1_LO = 3'd2,
        REG_ROW1_HI = 3'd3,
        REG_ROW3_LO = 3'd4,
        REG_ROW3_HI = 3'd5,
        REG_HALF_W  = 3'd6,
        REG_HALF_H  = 3'd7
    } reg_idx_t;

    // payload carried down the divider chain
    typedef struct packed {
        logic              vis;
        logic signed [63:0] n0;
        logic signed [63:0] n1;
        logic signed [63:0] n2;
        logic [HALF_W-1:0] hw;
        logic [HALF_W-1:0] hh;
    } wsp_pay_t;

    // reciprocal state carried along cells
    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] den;
        logic [DIVQ_W-1:0] quo;
    } wsp_div_t;

endpackage
`default_nettype wire

@@ hdl/wsp_cell.sv @@
`default_nettype none
// one restoring-division step: produces quotient bit for dividend bit BIT
module wsp_cell #(
    parameter int BIT = 0
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  en,
    input  wire                  vin,
    input  wsp_pkg::wsp_div_t    din,
    input  wsp_pkg::wsp_pay_t    pin,
    output logic                 vout,
    output wsp_pkg::wsp_div_t    dout,
    output wsp_pkg::wsp_pay_t    pout
);
    import wsp_pkg::*;

    logic      vld_reg;
    wsp_div_t  div_reg, div_next;
    wsp_pay_t  pay_reg;
    logic [64:0] trial;

    // shift in the next dividend bit (only bit 62 of 2^62 is one)
    always_comb
    begin
        trial = {din.rem, (BIT == RECIP_SH) ? 1'b1 : 1'b0};
        div_next = din;
        if (trial >= {1'b0, din.den})
        begin
            div_next.rem = 64'(trial - {1'b0, din.den});
            div_next.quo[BIT] = 1'b1;
        end
        else
        begin
            div_next.rem = trial[63:0];
            div_next.quo[BIT] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg <= div_next;
            pay_reg <= pin;
        end
    end

    assign vout = vld_reg;
    assign dout = div_reg;
    assign pout = pay_reg;

endmodule
`default_nettype wire

@@ hdl/wsp_back.sv @@
`default_nettype none
// ratio, scaling and saturation for one axis, three register stages
module wsp_back #(
    parameter int FRAC_BITS   = 16,
    parameter int COORD_WIDTH = 32,
    parameter bit SUBTRACT    = 1'b0
) (
    input  wire                        clk,
    input  wire                        en,
    input  wire signed [63:0]          num,
    input  wire [wsp_pkg::DIVQ_W-1:0]  recip,
    input  wire [wsp_pkg::HALF_W-1:0]  half,
    output logic signed [31:0]         res
);
    import wsp_pkg::*;

    localparam int SH = RECIP_SH - FRAC_BITS;
    localparam logic [RATIO_W-1:0] CAP = RATIO_W'(1) << 48;

    logic [63:0]  mag;
    logic         neg_s1_reg, neg_s2_reg, neg_s3_reg;
    logic [63:0]  pll_reg, plh_reg, phl_reg, phh_reg;
    logic [HALF_W-1:0] half_s1_reg, half_s2_reg, half_s3_reg;
    logic [127:0] prod;
    logic [127:0] shifted;
    logic [RATIO_W-1:0] rat_next, rat_reg;
    logic signed [63:0] off_reg;
    logic signed [63:0] sum;
    logic signed [63:0] hi_lim, lo_lim;
    logic signed [63:0] sat;

    assign mag = num[63] ? 64'(-num) : num;

    // stage 1: four 32x32 partial products of |N| * R
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pll_reg     <= mag[31:0] * {1'b0, recip[30:0]};
            plh_reg     <= mag[31:0] * {32'd0, recip[62:31]};
            phl_reg     <= mag[63:32] * {1'b0, recip[30:0]};
            phh_reg     <= mag[63:32] * {32'd0, recip[62:31]};
            neg_s1_reg  <= num[63];
            half_s1_reg <= half;
        end
    end

    // stage 2: combine, shift, cap
    always_comb
    begin
        prod = {64'd0, pll_reg} + ({64'd0, plh_reg} << 31)
             + ({64'd0, phl_reg} << 32) + ({64'd0, phh_reg} << 63);
        shifted = prod >> SH;
        if (shifted > {79'd0, CAP})
            rat_next = CAP;
        else
            rat_next = shifted[RATIO_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rat_reg     <= rat_next;
            neg_s2_reg  <= neg_s1_reg;
            half_s2_reg <= half_s1_reg;
        end
    end

    // stage 3: scale by half size
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            off_reg     <= $signed({3'd0, rat_reg, 12'd0} >> 12) * $signed({52'd0, half_s2_reg});
            neg_s3_reg  <= neg_s2_reg;
            half_s3_reg <= half_s2_reg;
        end
    end

    // center plus or minus offset, then saturate
    always_comb
    begin
        hi_lim = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
        lo_lim = -hi_lim - 64'sd1;
        if (neg_s3_reg ^ SUBTRACT)
            sum = ($signed({52'd0, half_s3_reg}) <<< FRAC_BITS) - off_reg;
        else
            sum = ($signed({52'd0, half_s3_reg}) <<< FRAC_BITS) + off_reg;
        if (sum > hi_lim)
            sat = hi_lim;
        else if (sum < lo_lim)
            sat = lo_lim;
        else
            sat = sum;
    end

    assign res = sat[31:0];

endmodule
`default_nettype wire

@@ hdl/world_to_screen_projection_top.sv @@
// World-to-screen projection.
// Input stream s_axis: tdata = {lift, pos_z, pos_y, pos_x}, 32 bits each.
// Output stream m_axis: tdata = {screen_top, screen_y, screen_x} (96 bits),
// tuser = visible.
// Configuration over APB: eight 64-bit registers at 8*i (rows 0, 1, 3 of the
// matrix, then half width and half height). Write only while idle.
// One point per cycle while the pipe is not stalled. The pipe holds the dot
// products, the reciprocal chain (one quotient bit per cell), ratio and scale,
// and an output register. The whole pipe advances together; when the receiver
// stalls with a full output register it freezes, and s_axis_tready drops.
// Reset empties the pipe and loads the register reset values (zero rows,
// 960 and 540).
`default_nettype none
module world_to_screen_projection_top #(
    parameter int FRAC_BITS   = 16,
    parameter int COORD_WIDTH = 32
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire [127:0]  s_axis_tdata,   // pos_x, pos_y, pos_z, lift
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [95:0]  m_axis_tdata,   // screen_x, screen_y, screen_top
    output logic         m_axis_tuser,   // visible
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire [wsp_pkg::ADDR_W-1:0] paddr,
    input  wire [63:0]   pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);
    import wsp_pkg::*;

    localparam int NCELL = DIVQ_W;

    logic [63:0] row_reg [6];
    logic [HALF_W-1:0] hw_reg, hh_reg;
    logic [2:0] ridx;
    logic wr;

    assign pready = 1'b1;
    assign ridx = paddr[5:3];
    assign wr = psel & penable & pwrite;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                row_reg[i] <= '0;
            hw_reg <= HALF_W'(960);
            hh_reg <= HALF_W'(540);
        end
        else if (wr)
        begin
            unique case (reg_idx_t'(ridx))
                REG_HALF_W: hw_reg <= pwdata[HALF_W-1:0];
                REG_HALF_H: hh_reg <= pwdata[HALF_W-1:0];
                default:    row_reg[ridx] <= pwdata;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx_t'(ridx))
            REG_HALF_W: prdata = {52'd0, hw_reg};
            REG_HALF_H: prdata = {52'd0, hh_reg};
            default:    prdata = row_reg[ridx];
        endcase
    end

    // pipeline advance
    logic en;
    logic out_vld_reg;
    assign en = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;

    // stage A: products and raised z
    logic signed [31:0] px, py, pz, pl;
    logic signed [32:0] zsum;
    logic signed [31:0] zt;
    assign px = s_axis_tdata[31:0];
    assign py = s_axis_tdata[63:32];
    assign pz = s_axis_tdata[95:64];
    assign pl = s_axis_tdata[127:96];
    assign zsum = 33'(pz) + 33'(pl);
    always_comb
    begin
        if (zsum > 33'sh0_7FFF_FFFF)
            zt = 32'sh7FFF_FFFF;
        else if (zsum < -33'sh0_8000_0000)
            zt = 32'sh8000_0000;
        else
            zt = zsum[31:0];
    end

    function automatic logic signed [31:0] cf(input logic [63:0] r, input bit hi);
        return hi ? r[63:32] : r[31:0];
    endfunction

    logic signed [63:0] p_reg [11];
    logic signed [31:0] c3_reg [3];
    logic a_vld_reg;
    logic [HALF_W-1:0] hwa_reg, hha_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else if (en)
            a_vld_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0]  <= cf(row_reg[0], 1'b0) * px;
            p_reg[1]  <= cf(row_reg[0], 1'b1) * py;
            p_reg[2]  <= cf(row_reg[1], 1'b0) * pz;
            p_reg[3]  <= cf(row_reg[2], 1'b0) * px;
            p_reg[4]  <= cf(row_reg[2], 1'b1) * py;
            p_reg[5]  <= cf(row_reg[3], 1'b0) * pz;
            p_reg[6]  <= cf(row_reg[3], 1'b0) * zt;
            p_reg[7]  <= cf(row_reg[4], 1'b0) * px;
            p_reg[8]  <= cf(row_reg[4], 1'b1) * py;
            p_reg[9]  <= cf(row_reg[5], 1'b0) * pz;
            p_reg[10] <= '0;
            c3_reg[0] <= cf(row_reg[1], 1'b1);
            c3_reg[1] <= cf(row_reg[3], 1'b1);
            c3_reg[2] <= cf(row_reg[5], 1'b1);
            hwa_reg   <= hw_reg;
            hha_reg   <= hh_reg;
        end
    end

    // stage B: sums of floored products
    logic signed [63:0] n0_reg, n1_reg, n2_reg, w_reg;
    logic b_vld_reg;
    logic [HALF_W-1:0] hwb_reg, hhb_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_vld_reg <= 1'b0;
        else if (en)
            b_vld_reg <= a_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n0_reg <= 64'(c3_reg[0]) + (p_reg[0] >>> FRAC_BITS) + (p_reg[1] >>> FRAC_BITS)
                    + (p_reg[2] >>> FRAC_BITS);
            n1_reg <= 64'(c3_reg[1]) + (p_reg[3] >>> FRAC_BITS) + (p_reg[4] >>> FRAC_BITS)
                    + (p_reg[5] >>> FRAC_BITS);
            n2_reg <= 64'(c3_reg[1]) + (p_reg[3] >>> FRAC_BITS) + (p_reg[4] >>> FRAC_BITS)
                    + (p_reg[6] >>> FRAC_BITS) + p_reg[10];
            w_reg  <= 64'(c3_reg[2]) + (p_reg[7] >>> FRAC_BITS) + (p_reg[8] >>> FRAC_BITS)
                    + (p_reg[9] >>> FRAC_BITS);
            hwb_reg <= hwa_reg;
            hhb_reg <= hha_reg;
        end
    end

    // stage C: threshold test, launch into the divider chain
    localparam logic signed [63:0] THRESH = 64'((1 << FRAC_BITS) / 100);
    wsp_pay_t c_pay;
    wsp_div_t c_div;
    always_comb
    begin
        c_pay.vis = w_reg > THRESH;
        c_pay.n0  = n0_reg;
        c_pay.n1  = n1_reg;
        c_pay.n2  = n2_reg;
        c_pay.hw  = hwb_reg;
        c_pay.hh  = hhb_reg;
        c_div.rem = '0;
        c_div.den = c_pay.vis ? w_reg : 64'd1;
        c_div.quo = '0;
    end

    // divider chain, one quotient bit per cell, MSB first
    logic      cv [NCELL+1];
    wsp_div_t  cd [NCELL+1];
    wsp_pay_t  cp [NCELL+1];
    assign cv[0] = b_vld_reg;
    assign cd[0] = c_div;
    assign cp[0] = c_pay;

    for (genvar g = 0; g < NCELL; g++)
    begin : g_cell
        wsp_cell #(.BIT(NCELL - 1 - g)) u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .en   (en),
            .vin  (cv[g]),
            .din  (cd[g]),
            .pin  (cp[g]),
            .vout (cv[g+1]),
            .dout (cd[g+1]),
            .pout (cp[g+1])
        );
    end

    // back end, three stages; valid and visible delayed alongside
    logic [2:0] bv_reg, bvis_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bv_reg <= '0;
        else if (en)
            bv_reg <= {bv_reg[1:0], cv[NCELL]};
    end
    always_ff @(posedge clk)
    begin
        if (en)
            bvis_reg <= {bvis_reg[1:0], cp[NCELL].vis};
    end

    logic signed [31:0] sx, sy, st;
    wsp_back #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH), .SUBTRACT(1'b0)) u_bx (
        .clk(clk), .en(en), .num(cp[NCELL].n0), .recip(cd[NCELL].quo),
        .half(cp[NCELL].hw), .res(sx));
    wsp_back #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH), .SUBTRACT(1'b1)) u_by (
        .clk(clk), .en(en), .num(cp[NCELL].n1), .recip(cd[NCELL].quo),
        .half(cp[NCELL].hh), .res(sy));
    wsp_back #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH), .SUBTRACT(1'b1)) u_bt (
        .clk(clk), .en(en), .num(cp[NCELL].n2), .recip(cd[NCELL].quo),
        .half(cp[NCELL].hh), .res(st));

    // output register
    logic [95:0] out_data_reg;
    logic        out_vis_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= bv_reg[2];
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_vis_reg  <= bvis_reg[2];
            out_data_reg <= bvis_reg[2] ? {st, sy, sx} : 96'd0;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_vis_reg;

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !m_axis_tready |=> out_vld_reg && $stable(out_data_reg))
        else $error("stalled result changed");
    // not visible means zero coordinates
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !out_vis_reg |-> out_data_reg == 96'd0)
        else $error("hidden point not zeroed");
    // input accepted exactly when the pipe moves
    a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!out_vld_reg || m_axis_tready))
        else $error("ready mismatch");

endmodule
`default_nettype wire

@@ dv/tb.sv @@
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import wsp_pkg::*;

    localparam int FRAC = 16;
    localparam int LATENCY = 69;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic              vis;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] top;
    } proj_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;   // pos_x, pos_y, pos_z, lift
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [95:0]  m_axis_tdata;   // screen_x, screen_y, screen_top
    logic         m_axis_tuser;   // visible
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [63:0]  pwdata;
    logic [63:0]  prdata;
    logic         pready;

    world_to_screen_projection_top u_top (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // shadow copy of the matrix and screen size
    logic [63:0] rows_q [6];
    logic [11:0] half_w_q;
    logic [11:0] half_h_q;

    proj_t  pending_proj [$];
    int     errors;
    longint cycles;
    bit     src_gaps;
    bit     sink_gaps;
    int     sink_hold;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    function automatic longint coef(input int row, input int col);
        logic [63:0] r;
        r = rows_q[row * 2 + col / 2];
        return longint'($signed(col % 2 ? r[63:32] : r[31:0]));
    endfunction

    function automatic longint row_dot(input int row, input longint x, input longint y,
                                       input longint z);
        return coef(row, 3) + ((coef(row, 0) * x) >>> FRAC)
             + ((coef(row, 1) * y) >>> FRAC) + ((coef(row, 2) * z) >>> FRAC);
    endfunction

    // signed n/w, magnitude truncated and capped at 2^48
    function automatic longint scaled_ratio(input longint n, input logic [63:0] recip);
        logic [63:0]  mag;
        logic [127:0] prod;
        logic [127:0] q;
        mag = n < 0 ? -n : n;
        prod = {64'd0, mag} * {64'd0, recip};
        q = prod >> (62 - FRAC);
        if (q > (128'd1 << 48))
            q = 128'd1 << 48;
        return n < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic logic [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 32'h7fffffff;
        if (v < -64'sd2147483648)
            return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic proj_t project_point(input logic [127:0] d);
        proj_t  p;
        longint x, y, z, zt, w, hw, hh;
        logic [63:0] recip;
        x = longint'($signed(d[31:0]));
        y = longint'($signed(d[63:32]));
        z = longint'($signed(d[95:64]));
        zt = z + longint'($signed(d[127:96]));
        if (zt > 64'sd2147483647)
            zt = 64'sd2147483647;
        if (zt < -64'sd2147483648)
            zt = -64'sd2147483648;
        p = '0;
        w = row_dot(2, x, y, z);
        if (w <= (64'sd1 << FRAC) / 100)
            return p;
        recip = (64'd1 << 62) / w;
        hw = half_w_q;
        hh = half_h_q;
        p.vis = 1'b1;
        p.sx = clamp32((hw << FRAC) + scaled_ratio(row_dot(0, x, y, z), recip) * hw);
        p.sy = clamp32((hh << FRAC) - scaled_ratio(row_dot(1, x, y, z), recip) * hh);
        p.top = clamp32((hh << FRAC) - scaled_ratio(row_dot(1, x, y, zt), recip) * hh);
        return p;
    endfunction

    task automatic reg_write(input reg_idx_t idx, input logic [63:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(idx) << 3;
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_HALF_W)
            half_w_q = val[11:0];
        else if (idx == REG_HALF_H)
            half_h_q = val[11:0];
        else
            rows_q[idx] = val;
    endtask

    // one point transaction, with optional leading gap
    task automatic send_point(input logic [127:0] d);
        if (src_gaps && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_proj.push_back(project_point(d));
        @(negedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_proj.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 32'h000fffff);
            3: return -$urandom_range(0, 32'h000fffff);
            default: return $urandom;
        endcase
    endfunction

    // random matrix: moderate gains, or random words in every field when wild
    task automatic load_matrix(input bit wild);
        reg_idx_t idx;
        for (int i = 0; i < 6; i++)
        begin
            idx = reg_idx_t'(i);
            if (wild)
                reg_write(idx, {rand_word(), rand_word()});
            else
                reg_write(idx, {32'($signed($urandom_range(0, 32'h60000)) - 32'sh30000),
                                32'($signed($urandom_range(0, 32'h40000)) - 32'sh20000)});
        end
    endtask

    function automatic logic [127:0] rand_point(input bit near);
        if (near)
            return {32'($signed($urandom_range(0, 32'h200000)) - 32'sh100000),
                    32'($urandom_range(0, 32'h400000)),
                    32'($signed($urandom_range(0, 32'h400000)) - 32'sh200000),
                    32'($signed($urandom_range(0, 32'h400000)) - 32'sh200000)};
        return {rand_word(), rand_word(), rand_word(), rand_word()};
    endfunction

    // result checker
    always @(posedge clk)
    begin
        proj_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_proj.size() == 0)
            begin
                $display("unexpected projection result");
                errors++;
            end
            else
            begin
                want = pending_proj.pop_front();
                if (m_axis_tuser !== want.vis)
                    report("visible", m_axis_tuser, want.vis);
                if (m_axis_tdata[31:0] !== want.sx)
                    report("screen_x", m_axis_tdata[31:0], want.sx);
                if (m_axis_tdata[63:32] !== want.sy)
                    report("screen_y", m_axis_tdata[63:32], want.sy);
                if (m_axis_tdata[95:64] !== want.top)
                    report("screen_top", m_axis_tdata[95:64], want.top);
            end
        end
    end

    // receiver stalls
    always @(negedge clk)
    begin
        if (sink_hold > 0)
        begin
            sink_hold <= sink_hold - 1;
            m_axis_tready <= 1'b0;
        end
        else if (sink_gaps && $urandom_range(0, 5) == 0)
        begin
            sink_hold <= $urandom_range(0, 11);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    task automatic test_reset_defaults();
        // zero matrix: w = 0, nothing visible
        send_point({32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000});
        send_point(128'd0);
        drain();
    endtask

    task automatic test_directed();
        reg_write(REG_ROW0_LO, {32'd0, 32'h00010000});
        reg_write(REG_ROW0_HI, {32'd0, 32'd0});
        reg_write(REG_ROW1_LO, {32'h00010000, 32'd0});
        reg_write(REG_ROW1_HI, {32'd0, 32'h00010000});
        reg_write(REG_ROW3_LO, {32'd0, 32'd0});
        reg_write(REG_ROW3_HI, {32'd0, 32'h00010000});
        reg_write(REG_HALF_W, 64'd4095);
        reg_write(REG_HALF_H, 64'd0);
        // w = z: threshold edges, behind viewer, huge ratios, lift overflow
        send_point({32'd0, 32'd655, 32'd1, 32'd1});
        send_point({32'd0, 32'd656, 32'd1, 32'd1});
        send_point({32'd5, 32'd1, 32'h7fffffff, 32'h80000000});
        send_point({32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff});
        send_point({32'h80000000, 32'h80000000, 32'd0, 32'd0});
        send_point({32'h80000000, 32'h00010000, 32'h00020000, 32'hfffe0000});
        send_point({32'h00030000, 32'h00020000, 32'hffff0000, 32'h00010000});
        drain();
        reg_write(REG_HALF_W, 64'd0);
        reg_write(REG_HALF_H, 64'hffff_ffff_ffff_ffff);
        send_point({32'h7fffffff, 32'h00010000, 32'h00005000, 32'hffff8000});
        send_point({32'h00010000, 32'h00000400, 32'h80000000, 32'h7fffffff});
        send_point({32'h12345678, 32'h00100000, 32'h00003000, 32'h00004000});
        drain();
    endtask

    task automatic test_random(input int n, input bit wild);
        load_matrix(wild);
        reg_write(REG_HALF_W, wild ? 64'd4095 : 64'($urandom_range(0, 2000)));
        reg_write(REG_HALF_H, wild ? 64'd1 : 64'($urandom_range(0, 2000)));
        for (int i = 0; i < n; i++)
            send_point(rand_point(!wild && $urandom_range(0, 4) != 0));
        drain();
    endtask

    // receiver holds off long enough to fill the pipe
    task automatic test_backpressure();
        @(posedge clk);
        sink_hold = 150;
        @(negedge clk);
        for (int i = 0; i < 100; i++)
            send_point(rand_point(1'b1));
        drain();
    endtask

    initial
    begin
        errors = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sink_hold = 0;
        src_gaps = 1'b0;
        sink_gaps = 1'b0;
        for (int i = 0; i < 6; i++)
            rows_q[i] = '0;
        half_w_q = 12'd960;
        half_h_q = 12'd540;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_directed();
        src_gaps = 1'b1;
        sink_gaps = 1'b1;
        test_random(200, 1'b0);
        test_random(100, 1'b1);
        test_backpressure();
        test_random(150, 1'b0);
        src_gaps = 1'b0;
        sink_gaps = 1'b0;
        test_random(150, 1'b0);

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire
